// ----- hdl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/stal_pkg.sv -----
// ---------------------------------------------------------------------------
// stal_pkg
// Types and constants shared by the symbol table lookup modules.
// ---------------------------------------------------------------------------
`default_nettype none

package stal_pkg;

  // Fixed field widths of the ports.
  localparam int unsigned QUERY_W   = 32;
  localparam int unsigned OUT_IDX_W = 10;
  localparam int unsigned OUT_ADR_W = 32;
  localparam int unsigned TYPE_W    = 8;
  localparam int unsigned OUT_OFS_W = 20;
  localparam int unsigned DIGIT_W   = 4;

  // Characters of the listing.
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] HEX_TEN  = 8'd10;

  typedef enum logic {
    CMD_TEXT   = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    PH_ADDR,
    PH_GAP1,
    PH_GAP2,
    PH_NAME
  } phase_e;

  typedef enum logic [1:0] {
    LK_IDLE,
    LK_WALK,
    LK_DONE
  } lk_state_e;

  typedef struct packed {
    logic parse_error;
    logic table_full;
  } stal_status_t;

endpackage

`default_nettype wire

// ----- hdl/stal_store.sv -----
// ---------------------------------------------------------------------------
// stal_store
// Entry memory: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
`default_nettype none

module stal_store #(
  parameter int unsigned WORD_W = 60,
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned IDX_W  = 10
) (
  input  wire logic              clk_i,
  input  wire logic              wr_en_i,
  input  wire logic [IDX_W-1:0]  wr_idx_i,
  input  wire logic [WORD_W-1:0] wr_data_i,
  input  wire logic              rd_en_i,
  input  wire logic [IDX_W-1:0]  rd_idx_i,
  output logic      [WORD_W-1:0] rd_data_o
);

  logic [WORD_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_idx_i] <= wr_data_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_idx_i];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/stal_cell.sv -----
// ---------------------------------------------------------------------------
// stal_cell
// One stage of the lookup chain: holds an entry and its index in registers.
// ---------------------------------------------------------------------------
`default_nettype none

module stal_cell #(
  parameter int unsigned WORD_W = 60,
  parameter int unsigned IDX_W  = 10
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              flush_i,
  input  wire logic              vld_i,
  input  wire logic [IDX_W-1:0]  idx_i,
  input  wire logic [WORD_W-1:0] word_i,
  output logic                   vld_o,
  output logic      [IDX_W-1:0]  idx_o,
  output logic      [WORD_W-1:0] word_o
);

  logic              vld_q;
  logic [IDX_W-1:0]  idx_q;
  logic [WORD_W-1:0] word_q;

  // Valid flag, cleared whenever the chain is not walking.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i & ~flush_i;
    end
  end

  // Payload moves on every cycle.
  always_ff @(posedge clk_i) begin
    idx_q  <= idx_i;
    word_q <= word_i;
  end

  assign vld_o  = vld_q;
  assign idx_o  = idx_q;
  assign word_o = word_q;

endmodule

`default_nettype wire

// ----- hdl/stal_parse.sv -----
// ---------------------------------------------------------------------------
// stal_parse
// Listing parser: turns text bytes into table entries and sticky flags.
// ---------------------------------------------------------------------------
`default_nettype none

module stal_parse #(
  parameter int unsigned MAX_ENTRIES = 1024,
  parameter int unsigned ADDR_BITS   = 32,
  parameter int unsigned OFFSET_BITS = 20,
  parameter int unsigned IDX_W       = 10,
  parameter int unsigned CNT_W       = 11
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       byte_vld_i,
  input  wire logic [7:0]                 text_byte_i,
  output logic                            wr_en_o,
  output logic      [IDX_W-1:0]           wr_idx_o,
  output logic      [ADDR_BITS-1:0]       wr_addr_o,
  output logic      [7:0]                 wr_type_o,
  output logic      [OFFSET_BITS-1:0]     wr_name_o,
  output logic      [CNT_W-1:0]           count_o,
  output stal_pkg::stal_status_t          status_o
);

  import stal_pkg::*;

  phase_e                 phase_q, phase_d;
  logic [ADDR_BITS-1:0]   accum_q, accum_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic [TYPE_W-1:0]      type_q, type_d;
  logic [OFFSET_BITS-1:0] name_q, name_d;
  logic [CNT_W-1:0]       count_q, count_d;
  stal_status_t           stat_q, stat_d;
  logic [DIGIT_W-1:0]     digit;
  logic                   bad_digit;
  logic                   commit;
  logic [OFFSET_BITS-1:0] commit_name;

  // Hex digit decode; anything else counts as zero and is flagged.
  always_comb begin
    digit     = '0;
    bad_digit = 1'b0;
    if (text_byte_i inside {[CH_0:CH_9]}) begin
      digit = DIGIT_W'(text_byte_i - CH_0);
    end else if (text_byte_i inside {[CH_A:CH_F]}) begin
      digit = DIGIT_W'(text_byte_i - CH_A + HEX_TEN);
    end else begin
      bad_digit = 1'b1;
    end
  end

  // Line parser and commit of completed lines.
  always_comb begin
    phase_d     = phase_q;
    accum_d     = accum_q;
    pos_d       = pos_q;
    type_d      = type_q;
    name_d      = name_q;
    count_d     = count_q;
    stat_d      = stat_q;
    commit      = 1'b0;
    commit_name = name_q;
    if (byte_vld_i) begin
      pos_d = pos_q + 1'b1;
      case (phase_q)
        PH_ADDR: begin
          if (text_byte_i == CH_SPACE) begin
            phase_d = PH_GAP1;
          end else if (text_byte_i == CH_NL) begin
            stat_d.parse_error = 1'b1;
            accum_d            = '0;
          end else begin
            if (bad_digit) begin
              stat_d.parse_error = 1'b1;
            end
            accum_d = (accum_q << DIGIT_W) | ADDR_BITS'(digit);
          end
        end
        PH_GAP1: begin
          if (text_byte_i == CH_NL) begin
            phase_d = PH_ADDR;
            accum_d = '0;
          end else if (text_byte_i != CH_SPACE) begin
            type_d  = text_byte_i;
            phase_d = PH_GAP2;
          end
        end
        PH_GAP2: begin
          if (text_byte_i == CH_NL) begin
            commit      = 1'b1;
            commit_name = pos_q;
          end else if (text_byte_i != CH_SPACE) begin
            name_d  = pos_q;
            phase_d = PH_NAME;
          end
        end
        PH_NAME: begin
          if (text_byte_i == CH_NL) begin
            commit = 1'b1;
          end
        end
        default: begin
          phase_d = PH_ADDR;
        end
      endcase
      if (commit) begin
        phase_d = PH_ADDR;
        accum_d = '0;
        if (count_q < CNT_W'(MAX_ENTRIES)) begin
          count_d = count_q + 1'b1;
        end else begin
          stat_d.table_full = 1'b1;
        end
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_ADDR;
      accum_q <= '0;
      pos_q   <= '0;
      count_q <= '0;
      stat_q  <= '0;
    end else begin
      phase_q <= phase_d;
      accum_q <= accum_d;
      pos_q   <= pos_d;
      count_q <= count_d;
      stat_q  <= stat_d;
    end
  end

  // Pending type and name offset of the current line.
  always_ff @(posedge clk_i) begin
    type_q <= type_d;
    name_q <= name_d;
  end

  assign wr_en_o   = commit && (count_q < CNT_W'(MAX_ENTRIES));
  assign wr_idx_o  = count_q[IDX_W-1:0];
  assign wr_addr_o = accum_q;
  assign wr_type_o = type_q;
  assign wr_name_o = commit_name;
  assign count_o   = count_q;
  assign status_o  = stat_q;

endmodule

`default_nettype wire

// ----- hdl/symbol_text_table_address_lookup_core.sv -----
// ---------------------------------------------------------------------------
// symbol_text_table_address_lookup_core
// Builds an entry table from a symbol listing and resolves address lookups.
// ---------------------------------------------------------------------------
//
//   Channel | Direction | Payload
//   --------+-----------+------------------------------------------------------
//   in      | input     | cmd_i, text_byte_i, query_addr_i
//   out     | output    | found_o, entry_index_o, entry_addr_o, entry_type_o,
//           |           | name_offset_o, parse_error_o, table_full_o
//
// A text byte is accepted while the core is idle and gives no output item.
// A lookup walks the stored entries through a two-cell chain fed by the entry
// memory's read port, one entry per cycle, until a hit, the last entry, a query
// below the first address or an empty table ends it. Its result waits in the
// walk result register until the output register is free; input is refused
// during a walk and while its result waits. A finished item waits in the output
// register while text bytes keep arriving. Reset clears all control state at
// once; the entry memory is not cleared, and only written entries are read.
`default_nettype none

module symbol_text_table_address_lookup_core #(
  parameter int unsigned MAX_ENTRIES = 1024,
  parameter int unsigned ADDR_BITS   = 32,
  parameter int unsigned OFFSET_BITS = 20
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        cmd_i,
  input  wire logic [7:0]  text_byte_i,
  input  wire logic [31:0] query_addr_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             found_o,
  output logic      [9:0]  entry_index_o,
  output logic      [31:0] entry_addr_o,
  output logic      [7:0]  entry_type_o,
  output logic      [19:0] name_offset_o,
  output logic             parse_error_o,
  output logic             table_full_o
);

  import stal_pkg::*;

  `include "assert_macros.svh"

  localparam int unsigned IDX_W  = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned WORD_W = ADDR_BITS + TYPE_W + OFFSET_BITS;

  lk_state_e              state_q, state_d;
  logic                   in_acc, byte_vld, lk_start;
  logic [ADDR_BITS-1:0]   query_q;
  logic [CNT_W-1:0]       rd_ptr_q;
  logic                   issue;
  logic                   rd_vld_q;
  logic [IDX_W-1:0]       rd_idx_q;
  logic [WORD_W-1:0]      rd_data;
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_idx;
  logic [ADDR_BITS-1:0]   wr_addr;
  logic [7:0]             wr_type;
  logic [OFFSET_BITS-1:0] wr_name;
  logic [CNT_W-1:0]       count;
  stal_status_t           stat;
  logic                   flush;
  logic                   c0_vld, c1_vld;
  logic [IDX_W-1:0]       c0_idx, c1_idx;
  logic [WORD_W-1:0]      c0_word, c1_word;
  logic [ADDR_BITS-1:0]   c0_addr;
  logic                   below, last, done, hit;
  logic                   res_found_q;
  logic [IDX_W-1:0]       res_idx_q;
  logic [WORD_W-1:0]      res_word_q;
  logic                   out_load;
  logic                   out_valid_q;
  logic                   out_found_q;
  logic [OUT_IDX_W-1:0]   out_idx_q;
  logic [OUT_ADR_W-1:0]   out_addr_q;
  logic [TYPE_W-1:0]      out_type_q;
  logic [OUT_OFS_W-1:0]   out_name_q;
  stal_status_t           out_stat_q;

  assign in_ready_o = (state_q == LK_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign byte_vld   = in_acc && (cmd_i == CMD_TEXT);
  assign lk_start   = in_acc && (cmd_i == CMD_LOOKUP);

  // Listing parser.
  stal_parse #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .ADDR_BITS  (ADDR_BITS),
    .OFFSET_BITS(OFFSET_BITS),
    .IDX_W      (IDX_W),
    .CNT_W      (CNT_W)
  ) u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .byte_vld_i (byte_vld),
    .text_byte_i(text_byte_i),
    .wr_en_o    (wr_en),
    .wr_idx_o   (wr_idx),
    .wr_addr_o  (wr_addr),
    .wr_type_o  (wr_type),
    .wr_name_o  (wr_name),
    .count_o    (count),
    .status_o   (stat)
  );

  // Entry memory.
  stal_store #(
    .WORD_W(WORD_W),
    .DEPTH (MAX_ENTRIES),
    .IDX_W (IDX_W)
  ) u_store (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_idx_i (wr_idx),
    .wr_data_i({wr_addr, wr_type, wr_name}),
    .rd_en_i  (issue),
    .rd_idx_i (rd_ptr_q[IDX_W-1:0]),
    .rd_data_o(rd_data)
  );

  // Read issue: one entry per cycle while walking, up to the stored count.
  assign issue = (state_q == LK_WALK) && (rd_ptr_q < count);
  assign flush = (state_q != LK_WALK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (lk_start) begin
        rd_ptr_q <= '0;
      end else if (issue) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      rd_vld_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= rd_ptr_q[IDX_W-1:0];
    if (lk_start) begin
      query_q <= ADDR_BITS'(query_addr_i);
    end
  end

  // Chain of two cells: the newest entry and its predecessor.
  stal_cell #(.WORD_W(WORD_W), .IDX_W(IDX_W)) u_cell0 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .flush_i(flush),
    .vld_i  (rd_vld_q),
    .idx_i  (rd_idx_q),
    .word_i (rd_data),
    .vld_o  (c0_vld),
    .idx_o  (c0_idx),
    .word_o (c0_word)
  );

  stal_cell #(.WORD_W(WORD_W), .IDX_W(IDX_W)) u_cell1 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .flush_i(flush),
    .vld_i  (c0_vld),
    .idx_i  (c0_idx),
    .word_i (c0_word),
    .vld_o  (c1_vld),
    .idx_o  (c1_idx),
    .word_o (c1_word)
  );

  // Compare the query against the newest entry in the chain.
  assign c0_addr = c0_word[WORD_W-1 -: ADDR_BITS];
  assign below   = query_q < c0_addr;
  assign last    = (CNT_W'(c0_idx) == count - 1'b1);
  assign hit     = c0_vld && c1_vld && below && (c0_idx != '0);
  assign done    = (count == '0) || (c0_vld && (below || last));

  // Lookup sequencer.
  always_comb begin
    state_d  = state_q;
    out_load = 1'b0;
    case (state_q)
      LK_IDLE: begin
        if (lk_start) begin
          state_d = LK_WALK;
        end
      end
      LK_WALK: begin
        if (done) begin
          state_d = LK_DONE;
        end
      end
      LK_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = LK_IDLE;
        end
      end
      default: begin
        state_d = LK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Walk result, held until the output register is free.
  always_ff @(posedge clk_i) begin
    if ((state_q == LK_WALK) && done) begin
      res_found_q <= hit;
      res_idx_q   <= c1_idx;
      res_word_q  <= c1_word;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_found_q <= res_found_q;
      out_stat_q  <= stat;
      if (res_found_q) begin
        out_idx_q  <= OUT_IDX_W'(res_idx_q);
        out_addr_q <= OUT_ADR_W'(res_word_q[WORD_W-1 -: ADDR_BITS]);
        out_type_q <= res_word_q[OFFSET_BITS +: TYPE_W];
        out_name_q <= OUT_OFS_W'(res_word_q[OFFSET_BITS-1:0]);
      end else begin
        out_idx_q  <= '0;
        out_addr_q <= '0;
        out_type_q <= '0;
        out_name_q <= '0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = out_found_q;
  assign entry_index_o = out_idx_q;
  assign entry_addr_o  = out_addr_q;
  assign entry_type_o  = out_type_q;
  assign name_offset_o = out_name_q;
  assign parse_error_o = out_stat_q.parse_error;
  assign table_full_o  = out_stat_q.table_full;

  // Checks on the sequencer, the miss outputs, the memory reads and the sticky flags.
  `ASSERT_NEXT(a_lookup_walks, lk_start, state_q == LK_WALK, "lookup did not start a walk")
  `ASSERT_SAME(a_miss_zero, out_valid_o && !found_o, entry_index_o == '0, "miss with index")
  `ASSERT_SAME(a_err_sticky, 1'b1, !$fell(stat.parse_error), "parse error flag cleared")
  `ASSERT_SAME(a_full_sticky, 1'b1, !$fell(stat.table_full), "table full flag cleared")
  `ASSERT_SAME(a_no_read_idle, state_q != LK_WALK, !issue, "memory read outside a walk")

endmodule

`default_nettype wire

// ----- tb/symbol_text_table_address_lookup_core_test.sv -----
// ---------------------------------------------------------------------------
// symbol_text_table_address_lookup_core_test
// Feeds symbol listings and lookups through the core and checks every item.
// The testbench keeps its own model of the entry table. It predicts each
// lookup result when the request is accepted and compares the output items
// in order. It also varies the idle patterns on both sides, holds off the
// receiver for a long stretch, and looks up the last entries of the table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module symbol_text_table_address_lookup_core_test;
  import stal_pkg::*;

  localparam int unsigned TBL_DEPTH = 1024;

  typedef struct {
    logic        found;
    logic [9:0]  index;
    logic [31:0] addr;
    logic [7:0]  etype;
    logic [19:0] name_ofs;
    logic        perr;
    logic        full;
  } lookup_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        cmd_i = CMD_TEXT;
  logic [7:0]  text_byte_i = '0;
  logic [31:0] query_addr_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        found_o;
  logic [9:0]  entry_index_o;
  logic [31:0] entry_addr_o;
  logic [7:0]  entry_type_o;
  logic [19:0] name_offset_o;
  logic        parse_error_o;
  logic        table_full_o;

  symbol_text_table_address_lookup_core dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .cmd_i, .text_byte_i, .query_addr_i,
    .out_valid_o, .out_ready_i, .found_o, .entry_index_o, .entry_addr_o,
    .entry_type_o, .name_offset_o, .parse_error_o, .table_full_o
  );

  // Shadow state of the listing parser and the entry table.
  phase_e      sh_phase = PH_ADDR;
  logic [31:0] sh_accum = '0;
  logic [19:0] sh_pos = '0;
  logic [7:0]  sh_type = '0;
  logic [19:0] sh_name = '0;
  logic [31:0] tbl_addr [TBL_DEPTH];
  logic [7:0]  tbl_type [TBL_DEPTH];
  logic [19:0] tbl_name [TBL_DEPTH];
  int unsigned tbl_count = 0;
  logic        sh_perr = 1'b0;
  logic        sh_full = 1'b0;

  lookup_res_t pending_results[$];
  int unsigned fail_count = 0;
  int unsigned items_sent = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_cycles = 0;
  logic [31:0] next_addr = 32'h0000_1000;

  // Clock.
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Overall time limit.
  initial begin
    #30ms;
    $display("FAIL symbol_text_table_address_lookup_core");
    $finish;
  end

  // Line parser model: one text byte.
  task automatic model_byte(input logic [7:0] c);
    logic [19:0] pos;
    logic [3:0]  dig;
    pos = sh_pos;
    sh_pos = sh_pos + 20'd1;
    case (sh_phase)
      PH_ADDR: begin
        if (c == CH_SPACE) begin
          sh_phase = PH_GAP1;
        end else if (c == CH_NL) begin
          sh_perr = 1'b1;
          sh_phase = PH_ADDR; sh_accum = '0; sh_type = '0; sh_name = '0;
        end else begin
          dig = '0;
          if (c >= CH_0 && c <= CH_9) dig = c - CH_0;
          else if (c >= CH_A && c <= CH_F) dig = c - CH_A + HEX_TEN;
          else sh_perr = 1'b1;
          sh_accum = {sh_accum[27:0], dig};
        end
      end
      PH_GAP1: begin
        if (c == CH_NL) begin
          sh_phase = PH_ADDR; sh_accum = '0; sh_type = '0; sh_name = '0;
        end else if (c != CH_SPACE) begin
          sh_type = c;
          sh_phase = PH_GAP2;
        end
      end
      default: begin
        if (sh_phase == PH_GAP2 && c != CH_SPACE) begin
          sh_name = pos;
          sh_phase = PH_NAME;
        end
        if (c == CH_NL && sh_phase == PH_NAME) begin
          if (tbl_count < TBL_DEPTH) begin
            tbl_addr[tbl_count] = sh_accum;
            tbl_type[tbl_count] = sh_type;
            tbl_name[tbl_count] = sh_name;
            tbl_count++;
          end else begin
            sh_full = 1'b1;
          end
          sh_phase = PH_ADDR; sh_accum = '0; sh_type = '0; sh_name = '0;
        end
      end
    endcase
  endtask

  // Table model: the entry whose successor first lies above the query.
  function automatic lookup_res_t model_lookup(input logic [31:0] q);
    lookup_res_t r;
    r = '{default: '0};
    r.perr = sh_perr;
    r.full = sh_full;
    if (tbl_count != 0 && q >= tbl_addr[0]) begin
      for (int i = 0; i + 1 < tbl_count; i++) begin
        if (q < tbl_addr[i + 1]) begin
          r.found = 1'b1;
          r.index = i[9:0];
          r.addr = tbl_addr[i];
          r.etype = tbl_type[i];
          r.name_ofs = tbl_name[i];
          break;
        end
      end
    end
    return r;
  endfunction

  // Offer one item, wait for it to be taken, then update the model.
  task automatic send_item(input cmd_e cmd, input logic [7:0] c, input logic [31:0] q);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= cmd;
    text_byte_i <= c;
    query_addr_i <= q;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    if (cmd == CMD_LOOKUP) pending_results.push_back(model_lookup(q));
    else model_byte(c);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(CMD_TEXT, s[i], $urandom);
  endtask

  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    return (n < 10) ? CH_0 + n : CH_A + n - HEX_TEN;
  endfunction

  // One well-formed line with random digit count, spacing and name length.
  task automatic send_line(input logic [31:0] a, input logic [7:0] t, input int name_len);
    int ndig;
    ndig = $urandom_range(8, 1);
    while (ndig < 8 && (a >> (4 * ndig)) != 0) ndig++;
    for (int i = ndig - 1; i >= 0; i--) send_item(CMD_TEXT, hex_digit(a[4 * i +: 4]), '0);
    repeat ($urandom_range(2, 1)) send_item(CMD_TEXT, CH_SPACE, '0);
    send_item(CMD_TEXT, t, '0);
    repeat ($urandom_range(2, 0)) send_item(CMD_TEXT, CH_SPACE, '0);
    for (int i = 0; i < name_len; i++) send_item(CMD_TEXT, 8'(8'h5f + $urandom_range(27)), '0);
    send_item(CMD_TEXT, CH_NL, '0);
  endtask

  // A query near a stored address, or anywhere.
  function automatic logic [31:0] pick_query();
    int unsigned k;
    if (tbl_count == 0 || $urandom_range(3) == 0) return $urandom;
    k = $urandom_range(tbl_count - 1);
    return tbl_addr[k] + $urandom_range(2) - 1;
  endfunction

  // Receiver: random stalls, long hold-off on request, and result checking.
  always @(posedge clk_i) begin
    lookup_res_t e;
    if (out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("output item with no lookup outstanding");
        fail_count++;
      end else begin
        e = pending_results.pop_front();
        if (found_o !== e.found) begin
          $error("found: expected %0d, got %0d", e.found, found_o); fail_count++;
        end
        if (entry_index_o !== e.index) begin
          $error("entry_index: expected %0d, got %0d", e.index, entry_index_o); fail_count++;
        end
        if (entry_addr_o !== e.addr) begin
          $error("entry_addr: expected %h, got %h", e.addr, entry_addr_o); fail_count++;
        end
        if (entry_type_o !== e.etype) begin
          $error("entry_type: expected %h, got %h", e.etype, entry_type_o); fail_count++;
        end
        if (name_offset_o !== e.name_ofs) begin
          $error("name_offset: expected %0d, got %0d", e.name_ofs, name_offset_o);
          fail_count++;
        end
        if (parse_error_o !== e.perr) begin
          $error("parse_error: expected %0d, got %0d", e.perr, parse_error_o); fail_count++;
        end
        if (table_full_o !== e.full) begin
          $error("table_full: expected %0d, got %0d", e.full, table_full_o); fail_count++;
        end
      end
    end
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic test_empty_table();
    send_item(CMD_LOOKUP, '0, 32'h0000_0000);
    send_item(CMD_LOOKUP, '0, 32'hffff_ffff);
  endtask

  // Extremes of the fields and each special case of the line format.
  task automatic test_directed_cases();
    send_text("1000 T a\n");
    send_item(CMD_LOOKUP, '0, 32'h0000_2000);         // one entry only: never a hit
    send_text("1fff t\n");                            // empty name
    send_text("2000  d  x\n");
    send_text("12\n");                                // newline inside the address
    send_text("3000 \n");                             // newline where the type is expected
    send_text("1234abcd9 W wrap\n");                  // address digits overflow
    send_text("FG 0 bad\n");                          // bad address characters
    send_text("ffffffff \xff \xff\n");
    send_item(CMD_LOOKUP, '0, 32'h0000_0fff);         // below the first address
    send_item(CMD_LOOKUP, '0, 32'h0000_1000);
    send_item(CMD_LOOKUP, '0, 32'h0000_1fff);
    send_item(CMD_LOOKUP, '0, 32'h0000_2000);
    send_item(CMD_LOOKUP, '0, 32'hffff_ffff);         // no successor above
    send_item(CMD_LOOKUP, '0, 32'h0000_0000);
  endtask

  // Mostly well-formed sorted lines, some noise and broken lines, and lookups.
  task automatic random_stretch(input int unsigned n_items);
    int unsigned stop_at;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4: begin
          next_addr = next_addr + $urandom_range(4096, 1);
          send_line(next_addr, $urandom, $urandom_range(4));
        end
        5, 6, 7: send_item(CMD_LOOKUP, '0, pick_query());
        8: send_item(CMD_TEXT, $urandom, '0);
        default: begin
          send_item(CMD_TEXT, hex_digit($urandom), '0);
          if ($urandom_range(1)) send_item(CMD_TEXT, CH_SPACE, '0);
          send_item(CMD_TEXT, CH_NL, '0);
        end
      endcase
    end
  endtask

  task automatic test_random_idling();
    send_idle_pct = 0;  recv_idle_pct = 0;  random_stretch(100);
    send_idle_pct = 75; recv_idle_pct = 0;  random_stretch(100);
    send_idle_pct = 0;  recv_idle_pct = 75; random_stretch(100);
    send_idle_pct = 33; recv_idle_pct = 33; random_stretch(100);
    send_idle_pct = 0;  recv_idle_pct = 0;
  endtask

  // Receiver holds off while lookups keep coming, so the input stalls.
  task automatic test_receiver_hold();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    hold_cycles = 400;
    repeat (6) begin
      send_item(CMD_LOOKUP, '0, pick_query());
      send_text("z");
    end
    send_item(CMD_TEXT, CH_NL, '0);
  endtask

  // Lookups at the last two entries, of which the last can never be a hit,
  // and at the first entry.
  task automatic test_table_full();
    if (tbl_count >= 2) begin
      send_item(CMD_LOOKUP, '0, tbl_addr[tbl_count - 2]);
      send_item(CMD_LOOKUP, '0, tbl_addr[tbl_count - 1]);
      send_item(CMD_LOOKUP, '0, tbl_addr[0]);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_table();
    test_directed_cases();
    test_random_idling();
    test_receiver_hold();
    test_table_full();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS symbol_text_table_address_lookup_core");
    end else begin
      $display("FAIL symbol_text_table_address_lookup_core");
    end
    $finish;
  end

endmodule
